@@ rtl/core/llts_pkg.sv @@
// Shared types and constants for the least-laxity task scheduler.
// Holds payload structs, cell command struct, status and FSM enums.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package llts_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF = 16;
    localparam int LAX_LIMIT     = 100000;
    localparam int SHORT_LIMIT   = 10000;
    localparam int COUNT_MAX     = 31;

    localparam logic OP_ADMIT = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic CFG_QUANTUM  = 1'b0;
    localparam logic CFG_EXPECTED = 1'b1;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DONE    = 2'd3
    } slot_status_t;

    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_EVAL  = 3'd1,
        S_SCAN  = 3'd2,
        S_APPLY = 3'd3,
        S_EMIT  = 3'd4
    } sched_state_t;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] service_time;
        logic [15:0] deadline;
    } in_item_t;

    typedef struct packed {
        logic       running_valid;
        logic [3:0] running_slot;
        logic       dispatched;
        logic       finished_valid;
        logic [3:0] finished_slot;
        logic       all_done;
        logic       halted;
    } out_item_t;

    // per-cell command strobes, already decoded for one slot
    typedef struct packed {
        logic admit;
        logic set_run;
        logic set_ready;
        logic dec;
        logic age;
    } cell_cmd_t;

endpackage
`default_nettype wire

@@ rtl/core/llts_cell.sv @@
// One task slot: holds status, remaining, wait and deadline of its task.
// Takes part in the candidate chain that finds the best slot. Uses llts_pkg.
`timescale 1ns / 1ps
`default_nettype none
module llts_cell #(
    parameter int TIME_BITS = 16,
    parameter int IW        = 4,
    parameter int IDX       = 0
) (
    input  wire                    clk,
    input  wire                    rst_n,
    input  llts_pkg::cell_cmd_t    cmd,
    input  wire  [15:0]            service_time,
    input  wire  [15:0]            deadline,
    input  wire                    scan_short,
    input  wire                    cand_found_in,
    input  wire  [TIME_BITS-1:0]   cand_key_in,
    input  wire  [IW-1:0]          cand_idx_in,
    output logic                   cand_found,
    output logic [TIME_BITS-1:0]   cand_key,
    output logic [IW-1:0]          cand_idx,
    output logic                   active,
    output logic                   rem_low
);
    import llts_pkg::*;

    localparam int CW = (TIME_BITS + 2 > 18) ? TIME_BITS + 2 : 18;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    slot_status_t           status_reg, status_next;
    logic                   started_reg, started_next;
    logic [TIME_BITS-1:0]   rem_reg, rem_next;
    logic [TIME_BITS-1:0]   wait_reg, wait_next;
    logic [TIME_BITS-1:0]   dl_reg, dl_next;
    logic signed [CW-1:0]   lax, rem_w;
    logic                   qual, take;
    logic [TIME_BITS-1:0]   own_key;

    always_comb
    begin
        status_next  = status_reg;
        started_next = started_reg;
        rem_next     = rem_reg;
        wait_next    = wait_reg;
        dl_next      = dl_reg;
        if (cmd.admit)
        begin
            status_next  = ST_READY;
            started_next = 1'b0;
            rem_next     = TIME_BITS'(service_time);
            dl_next      = TIME_BITS'(deadline);
            wait_next    = '0;
        end
        else
        begin
            if (cmd.set_run)
                status_next = ST_RUNNING;
            if (cmd.set_ready)
                status_next = ST_READY;
            if (cmd.dec)
            begin
                started_next = 1'b1;
                if (rem_reg != '0)
                    rem_next = rem_reg - 1'b1;
                if (rem_reg <= TIME_BITS'(1))
                    status_next = ST_DONE;
            end
            // age against the status this cycle leaves behind
            if (cmd.age && status_next == ST_READY && !started_next && wait_reg != TIME_MAX)
                wait_next = wait_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg  <= ST_EMPTY;
            started_reg <= 1'b0;
        end
        else
        begin
            status_reg  <= status_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        wait_reg <= wait_next;
        dl_reg   <= dl_next;
    end

    assign active  = (status_reg == ST_READY) || (status_reg == ST_RUNNING);
    assign rem_low = (rem_reg <= TIME_BITS'(1));

    always_comb
    begin
        rem_w = $signed({{(CW-TIME_BITS){1'b0}}, rem_reg});
        lax   = $signed({{(CW-TIME_BITS){1'b0}}, dl_reg})
              - $signed({{(CW-TIME_BITS){1'b0}}, wait_reg}) - rem_w;
        if (scan_short)
        begin
            qual    = active && (rem_w < $signed(CW'(SHORT_LIMIT)));
            own_key = rem_reg;
        end
        else
        begin
            qual    = active && (lax >= 0) && (lax < $signed(CW'(LAX_LIMIT)));
            own_key = lax[TIME_BITS-1:0];
        end
        // strict less keeps the lower slot on a tie
        take = qual && (!cand_found_in || own_key < cand_key_in);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cand_found <= 1'b0;
        else
            cand_found <= take || cand_found_in;
    end

    always_ff @(posedge clk)
    begin
        cand_key <= take ? own_key : cand_key_in;
        cand_idx <= take ? IW'(IDX) : cand_idx_in;
    end

endmodule
`default_nettype wire

@@ rtl/core/least_laxity_task_scheduler.sv @@
// An admit, and a tick that is halted, has no admissions or completes, goes
// from IDLE straight to EMIT; a tick without reselection goes IDLE, EVAL, EMIT,
// one that reselects IDLE, EVAL, SCAN, APPLY, EMIT, and the first dispatch IDLE,
// SCAN, APPLY, EMIT; one item in flight at a time, the next taken only after the
// result leaves with ready high. The candidate walk, one cell per cycle, sets the scan.
// Reset (rst_n, async): all slots empty, quantum 1, expected tasks 0, not halted.
`timescale 1ns / 1ps
`default_nettype none
module least_laxity_task_scheduler #(
    parameter int NUM_SLOTS = llts_pkg::NUM_SLOTS_DEF,
    parameter int TIME_BITS = llts_pkg::TIME_BITS_DEF
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  item_valid,
    output logic                 item_ready,
    input  llts_pkg::in_item_t   item,
    output logic                 result_valid,
    input  wire                  result_ready,
    output llts_pkg::out_item_t  result,
    input  wire                  cfg_we,
    input  wire                  cfg_addr,
    input  wire  [7:0]           cfg_wdata
);
    import llts_pkg::*;

    localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Control state
    sched_state_t   state_reg, state_next;
    logic           mode_short_reg, mode_short_next;
    logic [IW-1:0]  scan_cnt_reg, scan_cnt_next;
    logic           run_valid_reg, run_valid_next;
    logic [IW-1:0]  run_slot_reg, run_slot_next;
    logic           fin_reg, fin_next;
    logic [IW-1:0]  fin_slot_reg, fin_slot_next;
    logic           disp_reg, disp_next;
    logic [7:0]     qc_reg, qc_next;
    logic [7:0]     qt_reg;
    logic [4:0]     exp_reg;
    logic [4:0]     adm_reg, adm_next;
    logic           first_reg, first_next;
    logic           stopped_reg, stopped_next;
    logic           out_valid_reg, out_valid_next;
    out_item_t      out_reg, out_next;

    // Cell command decode
    logic           admit_en, run_en, ready_en, dec_en, age_en;
    logic [IW-1:0]  admit_slot, run_tgt;
    cell_cmd_t      cmd [NUM_SLOTS];

    // Candidate chain; entry 0 feeds the first cell an empty candidate
    logic                 found_chain [NUM_SLOTS+1];
    logic [TIME_BITS-1:0] key_chain   [NUM_SLOTS+1];
    logic [IW-1:0]        idx_chain   [NUM_SLOTS+1];
    logic [NUM_SLOTS-1:0] active_vec;
    logic [NUM_SLOTS-1:0] rem_low_vec;

    logic accept, in_range, done_now;

    assign found_chain[0] = 1'b0;
    assign key_chain[0]   = '0;
    assign idx_chain[0]   = '0;

    genvar g;
    generate
        for (g = 0; g < NUM_SLOTS; g++)
        begin : g_cell
            always_comb
            begin
                cmd[g].admit     = admit_en && (admit_slot == IW'(g));
                cmd[g].set_run   = run_en   && (run_tgt == IW'(g));
                cmd[g].set_ready = ready_en && (run_slot_reg == IW'(g));
                cmd[g].dec       = dec_en   && (run_slot_reg == IW'(g));
                cmd[g].age       = age_en;
            end

            llts_cell #(
                .TIME_BITS (TIME_BITS),
                .IW        (IW),
                .IDX       (g)
            ) u_cell (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd[g]),
                .service_time  (item.service_time),
                .deadline      (item.deadline),
                .scan_short    (mode_short_reg),
                .cand_found_in (found_chain[g]),
                .cand_key_in   (key_chain[g]),
                .cand_idx_in   (idx_chain[g]),
                .cand_found    (found_chain[g+1]),
                .cand_key      (key_chain[g+1]),
                .cand_idx      (idx_chain[g+1]),
                .active        (active_vec[g]),
                .rem_low       (rem_low_vec[g])
            );
        end
    endgenerate

    assign item_ready   = (state_reg == S_IDLE) && !out_valid_reg;
    assign accept       = item_valid && item_ready;
    assign in_range     = (32'(item.slot) < NUM_SLOTS);
    assign done_now     = (adm_reg != '0) && (adm_reg == exp_reg) && !(|active_vec);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration writes land at any edge with the write enable high
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qt_reg  <= 8'd1;
            exp_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_QUANTUM:  qt_reg  <= cfg_wdata;
                CFG_EXPECTED: exp_reg <= cfg_wdata[4:0];
                default:      qt_reg  <= qt_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        mode_short_next = mode_short_reg;
        scan_cnt_next   = scan_cnt_reg;
        run_valid_next  = run_valid_reg;
        run_slot_next   = run_slot_reg;
        fin_next        = fin_reg;
        fin_slot_next   = fin_slot_reg;
        disp_next       = disp_reg;
        qc_next         = qc_reg;
        adm_next        = adm_reg;
        first_next      = first_reg;
        stopped_next    = stopped_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        admit_en        = 1'b0;
        admit_slot      = IW'(item.slot);
        run_en          = 1'b0;
        run_tgt         = idx_chain[NUM_SLOTS];
        ready_en        = 1'b0;
        dec_en          = 1'b0;
        age_en          = 1'b0;

        // drop the result once the transfer completes
        if (out_valid_reg && result_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    disp_next  = 1'b0;
                    fin_next   = 1'b0;
                    state_next = S_EMIT;
                    if (stopped_reg)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (item.op == OP_ADMIT)
                    begin
                        if (in_range)
                        begin
                            admit_en = 1'b1;
                            if (adm_reg != 5'(COUNT_MAX))
                                adm_next = adm_reg + 1'b1;
                            // admitting over the running slot leaves nothing running
                            if (run_valid_reg && run_slot_reg == IW'(item.slot))
                                run_valid_next = 1'b0;
                        end
                    end
                    else if (adm_reg == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (done_now)
                    begin
                        stopped_next = 1'b1;
                    end
                    else if (!run_valid_reg && first_reg)
                    begin
                        first_next      = 1'b0;
                        mode_short_next = 1'b1;
                        scan_cnt_next   = '0;
                        state_next      = S_SCAN;
                    end
                    else
                    begin
                        if (run_valid_reg)
                        begin
                            dec_en        = 1'b1;
                            fin_next      = rem_low_vec[run_slot_reg];
                            fin_slot_next = run_slot_reg;
                        end
                        state_next = S_EVAL;
                    end
                end
            end

            S_EVAL:
            begin
                if (fin_reg)
                begin
                    run_valid_next = 1'b0;
                    qc_next        = '0;
                end
                if (!run_valid_reg || fin_reg || qc_reg == qt_reg)
                begin
                    mode_short_next = 1'b0;
                    scan_cnt_next   = '0;
                    state_next      = S_SCAN;
                end
                else
                begin
                    age_en     = 1'b1;
                    qc_next    = qc_reg + 1'b1;
                    state_next = S_EMIT;
                end
            end

            S_SCAN:
            begin
                // advance until the candidate has passed the last cell
                scan_cnt_next = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == IW'(NUM_SLOTS - 1))
                    state_next = S_APPLY;
            end

            S_APPLY:
            begin
                state_next = S_EMIT;
                if (!found_chain[NUM_SLOTS])
                begin
                    stopped_next = 1'b1;
                end
                else if (mode_short_reg)
                begin
                    run_en         = 1'b1;
                    run_valid_next = 1'b1;
                    run_slot_next  = idx_chain[NUM_SLOTS];
                    disp_next      = 1'b1;
                end
                else
                begin
                    age_en  = 1'b1;
                    qc_next = 8'd1;
                    if (!run_valid_reg || idx_chain[NUM_SLOTS] != run_slot_reg)
                    begin
                        run_en         = 1'b1;
                        ready_en       = run_valid_reg;
                        run_valid_next = 1'b1;
                        run_slot_next  = idx_chain[NUM_SLOTS];
                        disp_next      = 1'b1;
                    end
                end
            end

            S_EMIT:
            begin
                out_valid_next          = 1'b1;
                out_next.running_valid  = run_valid_reg;
                out_next.running_slot   = run_valid_reg ? 4'(run_slot_reg) : 4'd0;
                out_next.dispatched     = disp_reg;
                out_next.finished_valid = fin_reg;
                out_next.finished_slot  = fin_reg ? 4'(fin_slot_reg) : 4'd0;
                out_next.all_done       = done_now;
                out_next.halted         = stopped_reg;
                state_next              = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_short_reg <= 1'b0;
            scan_cnt_reg   <= '0;
            run_valid_reg  <= 1'b0;
            run_slot_reg   <= '0;
            fin_reg        <= 1'b0;
            fin_slot_reg   <= '0;
            disp_reg       <= 1'b0;
            qc_reg         <= '0;
            adm_reg        <= '0;
            first_reg      <= 1'b1;
            stopped_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            mode_short_reg <= mode_short_next;
            scan_cnt_reg   <= scan_cnt_next;
            run_valid_reg  <= run_valid_next;
            run_slot_reg   <= run_slot_next;
            fin_reg        <= fin_next;
            fin_slot_reg   <= fin_slot_next;
            disp_reg       <= disp_next;
            qc_reg         <= qc_next;
            adm_reg        <= adm_next;
            first_reg      <= first_next;
            stopped_reg    <= stopped_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // hold the result payload; only written when a new result is built
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !item_ready)
        else $error("input taken while an item is in progress");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt released without reset");

    a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    a_finished_not_running: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.finished_valid && result.running_valid)
        |-> (result.running_slot != result.finished_slot))
        else $error("finished slot still reported running");

endmodule
`default_nettype wire
